// File: rtl/core/sip_pkg.sv
// shared types, codes and character helpers for the suffixed integer parser
package sip_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned CharW = 8;
  localparam int unsigned AddrW = 4;

  localparam logic [DataW-1:0] AllOnes = {DataW{1'b1}};
  localparam logic [DataW-1:0] SignBit = {1'b1, {(DataW-1){1'b0}}};

  // register index, taken from paddr bit 3 (registers at byte 0 and 8)
  localparam logic RegMinIdx = 1'b0;
  localparam logic RegMaxIdx = 1'b1;

  localparam logic [CharW-1:0] ChNul   = 8'h00;
  localparam logic [CharW-1:0] ChPlus  = 8'h2b;
  localparam logic [CharW-1:0] ChMinus = 8'h2d;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChLowX  = 8'h78;
  localparam logic [CharW-1:0] ChUpX   = 8'h58;

  typedef enum logic [6:0] {
    PH_WS     = 7'b0000001,
    PH_SIGNED = 7'b0000010,
    PH_ZERO   = 7'b0000100,
    PH_XPFX   = 7'b0001000,
    PH_DIGITS = 7'b0010000,
    PH_TRAIL  = 7'b0100000,
    PH_BAD    = 7'b1000000
  } phase_e;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_OCT = 2'd1,
    RX_HEX = 2'd2
  } radix_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  // what the result stage needs of the parse state at the terminator
  typedef struct packed {
    logic             number;
    logic             negative;
    logic [DataW-1:0] accum;
  } parse_sum_t;

  function automatic logic is_ws(input logic [CharW-1:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // digit value, 16 when the character is no hex digit
  function automatic logic [4:0] digit_val(input logic [CharW-1:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h61 + 8'd10);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h41 + 8'd10);
    return v;
  endfunction

  // shift of a size suffix, zero when the character is none
  function automatic logic [5:0] suffix_shift(input logic [CharW-1:0] c);
    logic [CharW-1:0] lc;
    logic [5:0]       sh;
    lc = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
    case (lc)
      8'h62:   sh = 6'd9;
      8'h6b:   sh = 6'd10;
      8'h6d:   sh = 6'd20;
      8'h67:   sh = 6'd30;
      8'h74:   sh = 6'd40;
      8'h70:   sh = 6'd50;
      8'h65:   sh = 6'd60;
      default: sh = 6'd0;
    endcase
    return sh;
  endfunction

endpackage

// File: rtl/core/sip_parse_core.sv
// per-character parse state: phase, sign, radix, accumulator and overflow flag
module sip_parse_core import sip_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             clear_i,
  input  logic [CharW-1:0] char_i,
  output parse_sum_t       sum_o
);

  phase_e           phase_q, phase_d;
  radix_e           radix_q, radix_d, rad_use;
  logic             neg_q, neg_d;
  logic             ovf_q, ovf_d;
  logic [DataW-1:0] accum_q, accum_d;

  logic [4:0]       dig;
  logic [5:0]       sh;
  logic             ws;
  logic             take_digit, do_after, dig_ok;
  logic [DataW+3:0] acc_ext, prod;
  logic [DataW-1:0] hi_mask;

  assign dig     = digit_val(char_i);
  assign sh      = suffix_shift(char_i);
  assign ws      = is_ws(char_i);
  assign acc_ext = {4'd0, accum_q};
  assign hi_mask = ~(AllOnes >> sh);

  always_comb begin
    case (radix_q)
      RX_OCT:  dig_ok = dig < 5'd8;
      RX_HEX:  dig_ok = dig < 5'd16;
      default: dig_ok = dig < 5'd10;
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    radix_d    = radix_q;
    neg_d      = neg_q;
    ovf_d      = ovf_q;
    accum_d    = accum_q;
    rad_use    = radix_q;
    take_digit = 1'b0;
    do_after   = 1'b0;

    case (phase_q)
      PH_WS, PH_SIGNED: begin
        if (phase_q == PH_WS && ws) begin
          phase_d = PH_WS;
        end else if (phase_q == PH_WS && (char_i == ChPlus || char_i == ChMinus)) begin
          neg_d   = (char_i == ChMinus);
          phase_d = PH_SIGNED;
        end else if (char_i == ChZero) begin
          radix_d = RX_OCT;
          phase_d = PH_ZERO;
        end else if (dig < 5'd10) begin
          radix_d    = RX_DEC;
          rad_use    = RX_DEC;
          take_digit = 1'b1;
          phase_d    = PH_DIGITS;
        end else begin
          phase_d = PH_BAD;
        end
      end
      PH_ZERO: begin
        if (char_i == ChLowX || char_i == ChUpX) begin
          radix_d = RX_HEX;
          phase_d = PH_XPFX;
        end else if (dig < 5'd8) begin
          rad_use    = RX_OCT;
          take_digit = 1'b1;
          phase_d    = PH_DIGITS;
        end else begin
          do_after = 1'b1;
        end
      end
      PH_XPFX: begin
        if (dig < 5'd16) begin
          rad_use    = RX_HEX;
          take_digit = 1'b1;
          phase_d    = PH_DIGITS;
        end else begin
          phase_d = PH_BAD;
        end
      end
      PH_DIGITS: begin
        if (dig_ok) take_digit = 1'b1;
        else do_after = 1'b1;
      end
      PH_TRAIL: begin
        if (!ws) phase_d = PH_BAD;
      end
      default: phase_d = PH_BAD;
    endcase

    // multiply by the radix with shifts, overflow shows above bit 63
    case (rad_use)
      RX_OCT:  prod = (acc_ext << 3) + {{(DataW-1){1'b0}}, dig};
      RX_HEX:  prod = (acc_ext << 4) + {{(DataW-1){1'b0}}, dig};
      default: prod = (acc_ext << 3) + (acc_ext << 1) + {{(DataW-1){1'b0}}, dig};
    endcase

    if (take_digit && !ovf_q) begin
      if (prod[DataW+3:DataW] != 4'd0) begin
        accum_d = AllOnes;
        ovf_d   = 1'b1;
      end else begin
        accum_d = prod[DataW-1:0];
      end
    end

    if (do_after) begin
      if (ws) begin
        phase_d = PH_TRAIL;
      end else if (sh == 6'd0 || (accum_q & hi_mask) != '0) begin
        phase_d = PH_BAD;
      end else begin
        accum_d = accum_q << sh;
        phase_d = PH_TRAIL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WS;
      radix_q <= RX_DEC;
      neg_q   <= 1'b0;
      ovf_q   <= 1'b0;
      accum_q <= '0;
    end else if (clear_i) begin
      phase_q <= PH_WS;
      radix_q <= RX_DEC;
      neg_q   <= 1'b0;
      ovf_q   <= 1'b0;
      accum_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      radix_q <= radix_d;
      neg_q   <= neg_d;
      ovf_q   <= ovf_d;
      accum_q <= accum_d;
    end
  end

  assign sum_o.number   = (phase_q == PH_ZERO) || (phase_q == PH_DIGITS) ||
                          (phase_q == PH_TRAIL);
  assign sum_o.negative = neg_q;
  assign sum_o.accum    = accum_q;

endmodule

// File: rtl/core/sip_result.sv
// two-stage result path: sign and magnitude check, then range check and output register
module sip_result import sip_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  parse_sum_t       sum_i,
  input  logic [DataW-1:0] min_i,
  input  logic [DataW-1:0] max_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [DataW-1:0] value_o,
  output logic [1:0]       status_o
);

  logic             f1_v_q, out_v_q;
  logic [DataW-1:0] f1_val_q, f1_val_d, out_val_q, out_val_d;
  status_e          f1_st_q, f1_st_d, out_st_q, out_st_d;
  logic             out_en, f1_en;

  assign out_en  = !out_v_q || ready_i;
  assign f1_en   = !f1_v_q || out_en;
  assign ready_o = f1_en;

  always_comb begin
    f1_val_d = '0;
    f1_st_d  = ST_OK;
    if (!sum_i.number || (!sum_i.negative && sum_i.accum == AllOnes)) begin
      f1_st_d = ST_INVALID;
    end else if (sum_i.negative) begin
      if (sum_i.accum > SignBit) f1_st_d = ST_TOO_LARGE;
      else f1_val_d = '0 - sum_i.accum;
    end else begin
      if (sum_i.accum[DataW-1]) f1_st_d = ST_TOO_LARGE;
      else f1_val_d = sum_i.accum;
    end
  end

  always_comb begin
    out_st_d  = f1_st_q;
    out_val_d = f1_val_q;
    if (f1_st_q == ST_OK &&
        ($signed(f1_val_q) < $signed(min_i) || $signed(max_i) < $signed(f1_val_q))) begin
      out_st_d = ST_RANGE;
    end
    if (out_st_d != ST_OK) out_val_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (f1_en) f1_v_q <= valid_i;
      if (out_en) out_v_q <= f1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f1_en && valid_i) begin
      f1_val_q <= f1_val_d;
      f1_st_q  <= f1_st_d;
    end
    if (out_en && f1_v_q) begin
      out_val_q <= out_val_d;
      out_st_q  <= out_st_d;
    end
  end

  assign valid_o  = out_v_q;
  assign value_o  = out_val_q;
  assign status_o = out_st_q;

endmodule

// File: rtl/core/suffixed_integer_parser_unit.sv
// top level: input register, parse state, result path and register port
// Parses a zero-terminated text integer (optional sign, C-style 0x/0 radix prefix,
// optional size suffix b/k/m/g/t/p/e) arriving one character per transfer, and
// returns one value with a status for each terminating zero byte. One character
// is taken every cycle while no zero byte waits for the result path; the parse state
// is updated from the registered character. After the transfer of its zero byte, the
// result of a string passes the input register, the magnitude check and the range check
// into the output register, and the output register lets input continue while a
// result waits. min_value sits at byte 0 and max_value at byte 8, both 64 bits;
// write them only while no string is in flight.
module suffixed_integer_parser_unit import sip_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CharW-1:0] char_in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DataW-1:0] value_o,
  output logic [1:0]       status_o
);

  logic             s1_v_q;
  logic [CharW-1:0] char_q;
  logic [DataW-1:0] min_q, max_q;
  logic             is_term, fin_ready, s1_go, step, clear;
  parse_sum_t       sum;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == RegMaxIdx) ? max_q : min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= SignBit;
      max_q <= ~SignBit;
    end else if (psel && penable && pwrite) begin
      if (paddr[3] == RegMinIdx) min_q <= pwdata;
      else max_q <= pwdata;
    end
  end

  // a zero byte moves on only when the result path can take it
  assign is_term    = s1_v_q && (char_q == ChNul);
  assign step       = s1_v_q && (char_q != ChNul);
  assign clear      = is_term && fin_ready;
  assign s1_go      = step || clear;
  assign in_ready_o = !s1_v_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) char_q <= char_in_i;
  end

  sip_parse_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .clear_i (clear),
    .char_i  (char_q),
    .sum_o   (sum)
  );

  sip_result u_result (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (is_term),
    .ready_o  (fin_ready),
    .sum_i    (sum),
    .min_i    (min_q),
    .max_i    (max_q),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .value_o  (value_o),
    .status_o (status_o)
  );

endmodule
